### hdl/atrp_pkg.sv
// Shared types and constants for the answer-to-reset byte parser.
// Holds the parse phase and byte kind codes, the front-to-back record
// and the TA1 decode tables. No dependencies.
`default_nettype none

package atrp_pkg;

	// Parse phase of the front classifier
	typedef enum logic [2:0] {
		PH_WAIT_TS = 3'd0,
		PH_T0      = 3'd1,
		PH_IFACE   = 3'd2,
		PH_HIST    = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	// Kind of one classified byte
	typedef enum logic [2:0] {
		KIND_TS    = 3'd0,
		KIND_T0    = 3'd1,
		KIND_TA    = 3'd2,
		KIND_TB    = 3'd3,
		KIND_TC    = 3'd4,
		KIND_TD    = 3'd5,
		KIND_HIST  = 3'd6,
		KIND_EXTRA = 3'd7
	} kind_t;

	// Classified byte as handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [3:0]  slot;
		logic [7:0]  data;
		logic        done;
		logic [7:0]  ta1;
		logic [3:0]  hist_total;
	} rec_t;

	localparam int QUEUE_DEPTH = 2;

	// Clock-rate factor F from TA1 high nibble
	function automatic logic [11:0] f_lookup(input logic [3:0] code);
		logic [11:0] f;
		unique case (code)
			4'h0, 4'h1: f = 12'd372;
			4'h2:       f = 12'd558;
			4'h3:       f = 12'd744;
			4'h4:       f = 12'd1116;
			4'h5:       f = 12'd1488;
			4'h6:       f = 12'd1860;
			4'h9:       f = 12'd512;
			4'hA:       f = 12'd768;
			4'hB:       f = 12'd1024;
			4'hC:       f = 12'd1536;
			4'hD:       f = 12'd2048;
			default:    f = 12'd0;
		endcase
		return f;
	endfunction

	// Maximum card clock in MHz from TA1 high nibble
	function automatic logic [4:0] fmax_lookup(input logic [3:0] code);
		logic [4:0] m;
		unique case (code)
			4'h0:       m = 5'd4;
			4'h1, 4'h9: m = 5'd5;
			4'h2:       m = 5'd6;
			4'h3:       m = 5'd8;
			4'h4:       m = 5'd12;
			4'h5:       m = 5'd16;
			4'h6, 4'hD: m = 5'd20;
			4'hA:       m = 5'd7;
			4'hB:       m = 5'd10;
			4'hC:       m = 5'd15;
			default:    m = 5'd0;
		endcase
		return m;
	endfunction

	// Baud divisor D from TA1 low nibble
	function automatic logic [5:0] d_lookup(input logic [3:0] code);
		logic [5:0] d;
		unique case (code)
			4'h1:    d = 6'd1;
			4'h2:    d = 6'd2;
			4'h3:    d = 6'd4;
			4'h4:    d = 6'd8;
			4'h5:    d = 6'd16;
			4'h6:    d = 6'd32;
			4'h8:    d = 6'd12;
			4'h9:    d = 6'd20;
			default: d = 6'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

### hdl/atrp_front.sv
// Front classifier: tracks the answer structure and tags each byte.
// Writes one record per accepted byte into the queue.
// Depends on atrp_pkg.
`default_nettype none

module atrp_front #(
	parameter int MAX_GROUPS = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_start,
	output logic               rec_valid,
	input  wire logic          rec_ready,
	output atrp_pkg::rec_t     rec
);
	import atrp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  grp_q, grp_d;
	logic [3:0]  pend_q, pend_d;
	logic [3:0]  hleft_q, hleft_d;
	logic [3:0]  htot_q, htot_d;
	logic [7:0]  ta1_q, ta1_d;
	kind_t       kind;
	logic [3:0]  slot;
	logic        done;
	logic        acc;

	assign in_ready  = rec_ready;
	assign rec_valid = in_valid;
	assign acc       = in_valid && rec_ready;

	// State register, updated once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_TS;
			grp_q   <= '0;
			pend_q  <= '0;
			hleft_q <= '0;
			htot_q  <= '0;
			ta1_q   <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			grp_q   <= grp_d;
			pend_q  <= pend_d;
			hleft_q <= hleft_d;
			htot_q  <= htot_d;
			ta1_q   <= ta1_d;
		end
	end

	// Classification and next state
	always_comb begin
		phase_d = phase_q;
		grp_d   = grp_q;
		pend_d  = pend_q;
		hleft_d = hleft_q;
		htot_d  = htot_q;
		ta1_d   = ta1_q;
		kind    = KIND_EXTRA;
		slot    = '0;
		done    = 1'b0;
		if (in_start) begin
			// TS restarts the parse
			phase_d = PH_T0;
			grp_d   = '0;
			pend_d  = '0;
			hleft_d = '0;
			htot_d  = '0;
			ta1_d   = '0;
			kind    = KIND_TS;
		end else begin
			unique case (phase_q)
				PH_T0: begin
					kind    = KIND_T0;
					grp_d   = 3'd1;
					pend_d  = in_byte[7:4];
					htot_d  = in_byte[3:0];
					hleft_d = in_byte[3:0];
					if (in_byte[7:4] != 4'd0) begin
						phase_d = PH_IFACE;
					end else if (in_byte[3:0] != 4'd0) begin
						phase_d = PH_HIST;
					end else begin
						phase_d = PH_DONE;
						done    = 1'b1;
					end
				end
				PH_IFACE: begin
					slot = {1'b0, grp_q};
					priority if (pend_q[0]) begin
						kind   = KIND_TA;
						pend_d = pend_q & 4'he;
						if (grp_q == 3'd1) begin
							ta1_d = in_byte;
						end
					end else if (pend_q[1]) begin
						kind   = KIND_TB;
						pend_d = pend_q & 4'hc;
					end else if (pend_q[2]) begin
						kind   = KIND_TC;
						pend_d = pend_q & 4'h8;
					end else begin
						kind = KIND_TD;
						if (grp_q < 3'(MAX_GROUPS)) begin
							grp_d  = grp_q + 3'd1;
							pend_d = in_byte[7:4];
						end else begin
							pend_d = '0;
						end
					end
					// End of interface bytes
					if (pend_d == 4'd0) begin
						if (hleft_q != 4'd0) begin
							phase_d = PH_HIST;
						end else begin
							phase_d = PH_DONE;
							done    = 1'b1;
						end
					end
				end
				PH_HIST: begin
					kind    = KIND_HIST;
					slot    = htot_q - hleft_q + 4'd1;
					hleft_d = hleft_q - 4'd1;
					if (hleft_d == 4'd0) begin
						phase_d = PH_DONE;
						done    = 1'b1;
					end
				end
				default: begin
					// before TS or after the answer: extra byte, no change
				end
			endcase
		end
	end

	assign rec.kind       = kind;
	assign rec.slot       = slot;
	assign rec.data       = in_byte;
	assign rec.done       = done;
	assign rec.ta1        = ta1_d;
	assign rec.hist_total = htot_d;

	// Only T0, interface or historical bytes can end an answer
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec.done) |-> (rec.kind != KIND_TS && rec.kind != KIND_EXTRA))
		else $error("answer end flagged on TS or extra byte");

	// An accepted TS always leaves the parser expecting T0
	a_ts_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_start) |=> (phase_q == PH_T0 && pend_q == 4'd0))
		else $error("TS did not restart the parse");

endmodule

`default_nettype wire

### hdl/atrp_queue.sv
// Two-entry record queue between front classifier and back decoder.
// Lets either side stall without holding up the other.
// Depends on atrp_pkg.
`default_nettype none

module atrp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire atrp_pkg::rec_t push_rec,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output atrp_pkg::rec_t     pop_rec
);
	import atrp_pkg::*;

	localparam logic [1:0] FULL = 2'(QUEUE_DEPTH);

	rec_t        mem_q [QUEUE_DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_rec    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("queue count overflow");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == FULL) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

### hdl/atrp_back.sv
// Back end: decodes TA1 on the completing byte and holds the result beat
// in an output register. Depends on atrp_pkg.
`default_nettype none

module atrp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rec_valid,
	output logic               rec_ready,
	input  wire atrp_pkg::rec_t rec,
	output logic               out_valid,
	input  wire logic          out_ready,
	output atrp_pkg::kind_t    out_kind,
	output logic [3:0]         out_slot,
	output logic [7:0]         out_data,
	output logic               out_done,
	output logic [11:0]        out_f,
	output logic [4:0]         out_fmax,
	output logic [5:0]         out_d,
	output logic [3:0]         out_htot
);
	import atrp_pkg::*;

	logic        valid_q;
	logic        load;
	logic [11:0] f_dec;
	logic [4:0]  fmax_dec;
	logic [5:0]  d_dec;

	assign load      = rec_valid && (!valid_q || out_ready);
	assign rec_ready = !valid_q || out_ready;
	assign out_valid = valid_q;

	// TA1 decode, zero until the answer completes
	always_comb begin
		f_dec    = '0;
		fmax_dec = '0;
		d_dec    = '0;
		if (rec.done) begin
			f_dec    = f_lookup(rec.ta1[7:4]);
			fmax_dec = fmax_lookup(rec.ta1[7:4]);
			d_dec    = d_lookup(rec.ta1[3:0]);
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_kind <= rec.kind;
			out_slot <= rec.slot;
			out_data <= rec.data;
			out_done <= rec.done;
			out_f    <= f_dec;
			out_fmax <= fmax_dec;
			out_d    <= d_dec;
			out_htot <= rec.hist_total;
		end
	end

	a_zero_open: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_done) |-> (out_f == 12'd0 && out_fmax == 5'd0 && out_d == 6'd0))
		else $error("decoded TA1 fields shown before answer end");

	a_slot_ts: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (out_kind == KIND_TS || out_kind == KIND_T0 || out_kind == KIND_EXTRA))
			|-> (out_slot == 4'd0))
		else $error("slot index set on unnumbered byte");

endmodule

`default_nettype wire

### hdl/smart_card_atr_parser.sv
// Answer-to-reset byte parser, top level.
// Instantiates atrp_front, atrp_queue and atrp_back; uses atrp_pkg.
//
// Channel   Dir  Signals                      Content
// s_axis    in   tvalid tready tdata tuser    one received byte, TS flag
// m_axis    out  tvalid tready tdata tuser    classified byte, decode
//                tlast                        tlast = byte ends the answer
//
// One byte per cycle sustained while m_axis_tready stays high; a result is
// presented once its accepted beat has passed the queue, then the output register.
// While the output stalls, the two-entry queue and the output register
// absorb up to three beats before s_axis_tready drops. Reset is
// asynchronous, active low, and leaves the parser waiting for TS.
// No reset-time sweep: ready right after reset.
`default_nettype none

module smart_card_atr_parser #(
	parameter int MAX_GROUPS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic        s_axis_tuser,   // [0] start_of_answer
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [3:0] slot_index, [11:4] byte_echo,
	                                         // [23:12] clock_rate_factor,
	                                         // [28:24] max_clock_mhz,
	                                         // [34:29] baud_divisor,
	                                         // [38:35] historical_count, [39] zero
	output logic [2:0]       m_axis_tuser,   // [2:0] byte_kind
	output logic             m_axis_tlast    // answer_complete
);
	import atrp_pkg::*;

	rec_t        f_rec;
	logic        f_valid;
	logic        f_ready;
	rec_t        q_rec;
	logic        q_valid;
	logic        q_ready;
	kind_t       o_kind;
	logic [3:0]  o_slot;
	logic [7:0]  o_data;
	logic [11:0] o_f;
	logic [4:0]  o_fmax;
	logic [5:0]  o_d;
	logic [3:0]  o_htot;

	atrp_front #(
		.MAX_GROUPS(MAX_GROUPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_start  (s_axis_tuser),
		.rec_valid (f_valid),
		.rec_ready (f_ready),
		.rec       (f_rec)
	);

	atrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_rec   (f_rec),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_rec    (q_rec)
	);

	atrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_valid),
		.rec_ready (q_ready),
		.rec       (q_rec),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (o_kind),
		.out_slot  (o_slot),
		.out_data  (o_data),
		.out_done  (m_axis_tlast),
		.out_f     (o_f),
		.out_fmax  (o_fmax),
		.out_d     (o_d),
		.out_htot  (o_htot)
	);

	// Pack the result beat
	assign m_axis_tuser = o_kind;
	assign m_axis_tdata = {1'b0, o_htot, o_d, o_fmax, o_f, o_data, o_slot};

endmodule

`default_nettype wire
